// File: src/pida_pkg.sv
// Shared types and codes for the positional insert/delete array.
// No dependencies; the other files that use this package refer to it by scoped names.
package pida_pkg;

    typedef enum logic [2:0] {
        KIND_APPEND  = 3'd0,
        KIND_INSERT  = 3'd1,
        KIND_DELETE  = 3'd2,
        KIND_UPDATE  = 3'd3,
        KIND_DISPLAY = 3'd4
    } kind_t;

    typedef enum logic [1:0] {
        ST_ELEM    = 2'd0,
        ST_EMPTY   = 2'd1,
        ST_BAD_POS = 2'd2,
        ST_FULL    = 2'd3
    } res_status_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_SHIFT_RD,
        S_SHIFT_WR,
        S_COMMIT,
        S_EMIT_RD,
        S_EMIT_LOAD,
        S_ERR_FULL,
        S_ERR_POS,
        S_ERR_EMPTY
    } state_t;

    typedef enum logic [2:0] {
        PTR_HOLD,
        PTR_SHIFT_INIT,
        PTR_ZERO,
        PTR_STEP,
        PTR_INC
    } ptr_op_t;

    typedef enum logic [2:0] {
        RD_NONE,
        RD_SRC,
        RD_SRC_NEXT,
        RD_ZERO,
        RD_NEXT
    } rd_sel_t;

    typedef enum logic [1:0] {
        OUT_NONE,
        OUT_ELEM,
        OUT_ERR
    } out_op_t;

    typedef struct packed {
        logic        take;
        logic        append;
        logic        shift_wr;
        logic        commit;
        ptr_op_t     ptr_op;
        rd_sel_t     rd_sel;
        out_op_t     out_op;
        res_status_t err_status;
    } ctl_cmd_t;

    typedef struct packed {
        logic [2:0] kind;
        logic       full;
        logic       empty;
        logic       ins_pos_bad;
        logic       edit_pos_bad;
        logic       ins_shift;
        logic       del_shift;
        logic       shift_last;
        logic       elem_last;
        logic       can_load;
    } dp_stat_t;

endpackage

// File: src/pida_if.sv
// Valid/ready channel interfaces for input words and result words.
// Depends on nothing; used by the top level.
interface pida_item_if;
    logic               valid;
    logic               ready;
    logic [2:0]         kind;
    logic [4:0]         position;
    logic signed [31:0] value;

    modport source (output valid, kind, position, value, input ready);
    modport sink   (input valid, kind, position, value, output ready);
endinterface

interface pida_result_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] element;
    logic [3:0]         index;
    logic               last;
    logic [1:0]         status;

    modport source (output valid, element, index, last, status, input ready);
    modport sink   (input valid, element, index, last, status, output ready);
endinterface

// File: src/pida_ctrl.sv
// Sequencing state machine: decode, shift loop, commit, result emission.
// Depends on pida_pkg; drives the datapath through ctl_cmd_t.
module pida_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                item_valid,
    output logic                item_ready,
    input  pida_pkg::dp_stat_t  stat,
    output pida_pkg::ctl_cmd_t  cmd
);

    pida_pkg::state_t state_reg;
    pida_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= pida_pkg::S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        item_ready     = 1'b0;
        cmd.take       = 1'b0;
        cmd.append     = 1'b0;
        cmd.shift_wr   = 1'b0;
        cmd.commit     = 1'b0;
        cmd.ptr_op     = pida_pkg::PTR_HOLD;
        cmd.rd_sel     = pida_pkg::RD_NONE;
        cmd.out_op     = pida_pkg::OUT_NONE;
        cmd.err_status = pida_pkg::ST_ELEM;

        case (state_reg)
            pida_pkg::S_IDLE:
            begin
                item_ready = 1'b1;
                if (item_valid)
                begin
                    cmd.take   = 1'b1;
                    state_next = pida_pkg::S_DECODE;
                end
            end

            pida_pkg::S_DECODE:
            begin
                case (stat.kind)
                    pida_pkg::KIND_APPEND:
                    begin
                        if (stat.full)
                        begin
                            state_next = pida_pkg::S_ERR_FULL;
                        end
                        else
                        begin
                            cmd.append = 1'b1;
                            state_next = pida_pkg::S_IDLE;
                        end
                    end
                    pida_pkg::KIND_INSERT:
                    begin
                        // full check wins over the position check
                        if (stat.full)
                        begin
                            state_next = pida_pkg::S_ERR_FULL;
                        end
                        else if (stat.ins_pos_bad)
                        begin
                            state_next = pida_pkg::S_ERR_POS;
                        end
                        else if (stat.ins_shift)
                        begin
                            cmd.ptr_op = pida_pkg::PTR_SHIFT_INIT;
                            state_next = pida_pkg::S_SHIFT_RD;
                        end
                        else
                        begin
                            state_next = pida_pkg::S_COMMIT;
                        end
                    end
                    pida_pkg::KIND_DELETE:
                    begin
                        if (stat.edit_pos_bad)
                        begin
                            state_next = pida_pkg::S_ERR_POS;
                        end
                        else if (stat.del_shift)
                        begin
                            cmd.ptr_op = pida_pkg::PTR_SHIFT_INIT;
                            state_next = pida_pkg::S_SHIFT_RD;
                        end
                        else
                        begin
                            state_next = pida_pkg::S_COMMIT;
                        end
                    end
                    pida_pkg::KIND_UPDATE:
                    begin
                        if (stat.edit_pos_bad)
                        begin
                            state_next = pida_pkg::S_ERR_POS;
                        end
                        else
                        begin
                            state_next = pida_pkg::S_COMMIT;
                        end
                    end
                    pida_pkg::KIND_DISPLAY:
                    begin
                        state_next = pida_pkg::S_EMIT_RD;
                    end
                    default:
                    begin
                        state_next = pida_pkg::S_IDLE;
                    end
                endcase
            end

            pida_pkg::S_SHIFT_RD:
            begin
                cmd.rd_sel = pida_pkg::RD_SRC;
                state_next = pida_pkg::S_SHIFT_WR;
            end

            pida_pkg::S_SHIFT_WR:
            begin
                // write this entry and fetch the source of the next one together
                cmd.shift_wr = 1'b1;
                cmd.ptr_op   = pida_pkg::PTR_STEP;
                if (stat.shift_last)
                begin
                    state_next = pida_pkg::S_COMMIT;
                end
                else
                begin
                    cmd.rd_sel = pida_pkg::RD_SRC_NEXT;
                end
            end

            pida_pkg::S_COMMIT:
            begin
                cmd.commit = 1'b1;
                state_next = pida_pkg::S_EMIT_RD;
            end

            pida_pkg::S_EMIT_RD:
            begin
                if (stat.empty)
                begin
                    state_next = pida_pkg::S_ERR_EMPTY;
                end
                else
                begin
                    cmd.ptr_op = pida_pkg::PTR_ZERO;
                    cmd.rd_sel = pida_pkg::RD_ZERO;
                    state_next = pida_pkg::S_EMIT_LOAD;
                end
            end

            pida_pkg::S_EMIT_LOAD:
            begin
                if (stat.can_load)
                begin
                    cmd.out_op = pida_pkg::OUT_ELEM;
                    if (stat.elem_last)
                    begin
                        state_next = pida_pkg::S_IDLE;
                    end
                    else
                    begin
                        cmd.ptr_op = pida_pkg::PTR_INC;
                        cmd.rd_sel = pida_pkg::RD_NEXT;
                    end
                end
            end

            pida_pkg::S_ERR_FULL:
            begin
                cmd.err_status = pida_pkg::ST_FULL;
                if (stat.can_load)
                begin
                    cmd.out_op = pida_pkg::OUT_ERR;
                    state_next = pida_pkg::S_IDLE;
                end
            end

            pida_pkg::S_ERR_POS:
            begin
                cmd.err_status = pida_pkg::ST_BAD_POS;
                if (stat.can_load)
                begin
                    cmd.out_op = pida_pkg::OUT_ERR;
                    state_next = pida_pkg::S_IDLE;
                end
            end

            pida_pkg::S_ERR_EMPTY:
            begin
                cmd.err_status = pida_pkg::ST_EMPTY;
                if (stat.can_load)
                begin
                    cmd.out_op = pida_pkg::OUT_ERR;
                    state_next = pida_pkg::S_IDLE;
                end
            end

            default:
            begin
                state_next = pida_pkg::S_IDLE;
            end
        endcase
    end

endmodule

// File: src/pida_datapath.sv
// Element memory, count, pointer, address muxing and the output word register.
// Depends on pida_pkg; commanded by pida_ctrl.
module pida_datapath #(
    parameter int DEPTH = 16
) (
    input  logic                clk,
    input  logic                rst_n,
    input  pida_pkg::ctl_cmd_t  cmd,
    output pida_pkg::dp_stat_t  stat,
    input  logic [2:0]          in_kind,
    input  logic [4:0]          in_position,
    input  logic signed [31:0]  in_value,
    output logic                out_valid,
    input  logic                out_ready,
    output logic signed [31:0]  out_element,
    output logic [3:0]          out_index,
    output logic                out_last,
    output logic [1:0]          out_status
);

    localparam int CW   = $clog2(DEPTH + 1);
    localparam int AW   = $clog2(DEPTH);
    localparam int CMPW = (CW > 5) ? CW : 5;
    localparam int EW   = CMPW + 1;

    logic [2:0]         kind_reg;
    logic [4:0]         pos_reg;
    logic signed [31:0] value_reg;
    logic [CW-1:0]      count_reg;
    logic [AW-1:0]      ptr_reg;
    logic signed [31:0] rd_data_reg;

    logic signed [31:0] mem [DEPTH];

    logic               out_valid_reg;
    logic signed [31:0] out_element_reg;
    logic [3:0]         out_index_reg;
    logic               out_last_reg;
    logic [1:0]         out_status_reg;

    logic               is_insert;
    logic [AW-1:0]      ptr_shift;
    logic [AW-1:0]      ptr_shift2;
    logic [EW-1:0]      pos_ext;
    logic [EW-1:0]      count_ext;
    logic [EW-1:0]      ptr_ext;

    logic               rd_en;
    logic [AW-1:0]      rd_addr;
    logic               wr_en;
    logic [AW-1:0]      wr_addr;
    logic signed [31:0] wr_data;

    assign is_insert  = (kind_reg == pida_pkg::KIND_INSERT);
    // insert moves entries up (source below), delete moves them down
    assign ptr_shift  = is_insert ? (ptr_reg - AW'(1)) : (ptr_reg + AW'(1));
    assign ptr_shift2 = is_insert ? (ptr_reg - AW'(2)) : (ptr_reg + AW'(2));
    assign pos_ext    = EW'(pos_reg);
    assign count_ext  = EW'(count_reg);
    assign ptr_ext    = EW'(ptr_reg);

    assign stat.kind         = kind_reg;
    assign stat.full         = (count_ext == EW'(DEPTH));
    assign stat.empty        = (count_reg == '0);
    assign stat.ins_pos_bad  = (pos_ext > count_ext);
    assign stat.edit_pos_bad = (pos_ext >= count_ext);
    assign stat.ins_shift    = (count_ext > pos_ext);
    assign stat.del_shift    = ((pos_ext + EW'(1)) < count_ext);
    assign stat.shift_last   = is_insert ? (ptr_ext == (pos_ext + EW'(1)))
                                         : ((ptr_ext + EW'(2)) == count_ext);
    assign stat.elem_last    = ((ptr_ext + EW'(1)) == count_ext);
    assign stat.can_load     = !out_valid_reg || out_ready;

    always_ff @(posedge clk)
    begin
        if (cmd.take)
        begin
            kind_reg  <= in_kind;
            pos_reg   <= in_position;
            value_reg <= in_value;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else if (cmd.append)
        begin
            count_reg <= count_reg + CW'(1);
        end
        else if (cmd.commit)
        begin
            if (kind_reg == pida_pkg::KIND_INSERT)
            begin
                count_reg <= count_reg + CW'(1);
            end
            else if (kind_reg == pida_pkg::KIND_DELETE)
            begin
                count_reg <= count_reg - CW'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ptr_reg <= '0;
        end
        else
        begin
            case (cmd.ptr_op)
                pida_pkg::PTR_SHIFT_INIT: ptr_reg <= is_insert ? AW'(count_reg) : AW'(pos_reg);
                pida_pkg::PTR_ZERO:       ptr_reg <= '0;
                pida_pkg::PTR_STEP:       ptr_reg <= ptr_shift;
                pida_pkg::PTR_INC:        ptr_reg <= ptr_reg + AW'(1);
                default:                  ptr_reg <= ptr_reg;
            endcase
        end
    end

    always_comb
    begin
        rd_en   = 1'b1;
        rd_addr = '0;
        case (cmd.rd_sel)
            pida_pkg::RD_SRC:      rd_addr = ptr_shift;
            pida_pkg::RD_SRC_NEXT: rd_addr = ptr_shift2;
            pida_pkg::RD_ZERO:     rd_addr = '0;
            pida_pkg::RD_NEXT:     rd_addr = ptr_reg + AW'(1);
            default:               rd_en   = 1'b0;
        endcase
    end

    always_comb
    begin
        wr_en   = 1'b0;
        wr_addr = AW'(pos_reg);
        wr_data = value_reg;
        if (cmd.append)
        begin
            wr_en   = 1'b1;
            wr_addr = AW'(count_reg);
        end
        else if (cmd.shift_wr)
        begin
            wr_en   = 1'b1;
            wr_addr = ptr_reg;
            wr_data = rd_data_reg;
        end
        else if (cmd.commit && (kind_reg == pida_pkg::KIND_INSERT ||
                                kind_reg == pida_pkg::KIND_UPDATE))
        begin
            wr_en = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.out_op != pida_pkg::OUT_NONE)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        case (cmd.out_op)
            pida_pkg::OUT_ELEM:
            begin
                out_element_reg <= rd_data_reg;
                out_index_reg   <= 4'(ptr_reg);
                out_last_reg    <= stat.elem_last;
                out_status_reg  <= pida_pkg::ST_ELEM;
            end
            pida_pkg::OUT_ERR:
            begin
                out_element_reg <= '0;
                out_index_reg   <= '0;
                out_last_reg    <= 1'b1;
                out_status_reg  <= cmd.err_status;
            end
            default:
            begin
                out_element_reg <= out_element_reg;
            end
        endcase
    end

    assign out_valid   = out_valid_reg;
    assign out_element = out_element_reg;
    assign out_index   = out_index_reg;
    assign out_last    = out_last_reg;
    assign out_status  = out_status_reg;

endmodule

// File: src/positional_insert_delete_array_top.sv
// Positional insert/delete array: ordered list of up to DEPTH signed words with
// append, insert, delete, update and display. Takes one input word at a time.
// Insert and delete move each later entry through the element memory, which
// has one read and one write port, one entry per cycle after a read prime
// state; each edit then lists the array, one result per cycle while the
// result channel is not stalled. After reset no clearing is needed.
// Depends on pida_pkg, pida_if, pida_ctrl and pida_datapath.
module positional_insert_delete_array_top #(
    parameter int DEPTH = 16
) (
    input  logic           clk,
    input  logic           rst_n,
    pida_item_if.sink      item,
    pida_result_if.source  result
);

    pida_pkg::ctl_cmd_t cmd;
    pida_pkg::dp_stat_t stat;

    pida_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item.valid),
        .item_ready (item.ready),
        .stat       (stat),
        .cmd        (cmd)
    );

    pida_datapath #(
        .DEPTH (DEPTH)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .stat        (stat),
        .in_kind     (item.kind),
        .in_position (item.position),
        .in_value    (item.value),
        .out_valid   (result.valid),
        .out_ready   (result.ready),
        .out_element (result.element),
        .out_index   (result.index),
        .out_last    (result.last),
        .out_status  (result.status)
    );

endmodule

// File: src/pida_checker.sv
// Port-level checks for the positional insert/delete array, bound to the top.
// Depends on pida_pkg and positional_insert_delete_array_top.
module pida_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        item_valid,
    input logic        item_ready,
    input logic        res_valid,
    input logic        res_ready,
    input logic [31:0] res_element,
    input logic [3:0]  res_index,
    input logic        res_last,
    input logic [1:0]  res_status
);

    // a stalled result word keeps its payload
    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable(res_element) &&
        $stable(res_index) && $stable(res_last) && $stable(res_status))
        else $error("result word changed while stalled");

    // error and empty words are single, zeroed, final words
    a_err_shape: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && (res_status != pida_pkg::ST_ELEM) |->
        res_last && (res_element == '0) && (res_index == '0))
        else $error("malformed error word");

    // one word in flight: no accept right after an accept
    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && item_ready |=> !item_ready)
        else $error("input accepted while busy");

    // no new input while a listing still has words to deliver
    a_no_take_mid_list: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_last |-> !item_ready)
        else $error("input ready in the middle of a listing");

endmodule

bind positional_insert_delete_array_top pida_checker u_pida_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .item_valid  (item.valid),
    .item_ready  (item.ready),
    .res_valid   (result.valid),
    .res_ready   (result.ready),
    .res_element (result.element),
    .res_index   (result.index),
    .res_last    (result.last),
    .res_status  (result.status)
);
